[hw/rtl/dfr_pkg.sv]
// Shared constants and types for the delimited frame receiver.
package dfr_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int POS_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W        = 16;
    localparam int LEN_W        = 6;

    localparam logic [7:0] START_CODE_RST = 8'h55;
    localparam logic [7:0] END_CODE_RST   = 8'hAA;

    // configuration register indexes
    localparam logic CFG_START_CODE = 1'b0;
    localparam logic CFG_END_CODE   = 1'b1;

    // registered input request handed from the input stage to the frame core
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_rx_req;

endpackage

[hw/rtl/dfr_input_stage.sv]
// Input register stage: captures one received byte per request.
module dfr_input_stage
    import dfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output t_rx_req    o_req,
    input  logic       i_consume
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic [7:0] n_data;

    assign o_rx_ready = !r_valid || i_consume;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (o_rx_ready) begin
            n_valid = i_rx_valid;
            if (i_rx_valid) begin
                n_data = i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_req.valid = r_valid;
    assign o_req.data  = r_data;

endmodule

[hw/rtl/dfr_frame_core.sv]
// Frame state, running checksum and result register.
module dfr_frame_core
    import dfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  t_rx_req          i_req,
    output logic             o_consume,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic [7:0]       o_address,
    output logic [7:0]       o_type_code,
    output logic [7:0]       o_data_length,
    output logic [7:0]       o_data_first,
    output logic [7:0]       o_data_second,
    output logic [LEN_W-1:0] o_frame_length,
    output logic             o_checksum_ok,
    output logic             o_overflow
);

    logic [7:0]       r_start_code;
    logic [7:0]       r_end_code;
    logic             r_in_frame;
    logic [POS_W-1:0] r_pos;
    logic             r_drop;
    logic [SUM_W-1:0] r_sum;     // sum of bytes 1..pos-3
    logic [7:0]       r_last1;   // byte pos-1
    logic [7:0]       r_last2;   // byte pos-2
    logic [7:0]       r_b1, r_b2, r_b3, r_b4, r_b5;

    logic             n_in_frame;
    logic [POS_W-1:0] n_pos;
    logic             n_drop;
    logic [SUM_W-1:0] n_sum;
    logic [7:0]       n_last1;
    logic [7:0]       n_last2;

    logic             is_start;
    logic             is_end;
    logic             emit;
    logic             clear;
    logic             out_free;
    logic [POS_W-1:0] pos_v;
    logic             drop_v;
    logic [SUM_W-1:0] sum_v;
    logic             room;
    logic             sum_ok;

    logic             r_out_valid;
    logic [7:0]       r_address, r_type_code, r_data_length, r_data_first, r_data_second;
    logic [LEN_W-1:0] r_frame_length;
    logic             r_checksum_ok;
    logic             r_overflow;

    assign is_start = i_req.data == r_start_code;
    assign is_end   = i_req.data == r_end_code;
    assign emit     = is_end && (is_start || r_in_frame);
    assign clear    = is_start || (is_end && !r_in_frame);
    assign out_free = !r_out_valid || i_res_ready;
    assign o_consume = i_req.valid && (!emit || out_free);

    // state as seen after a start or restart has cleared it
    assign pos_v  = clear ? '0 : r_pos;
    assign drop_v = clear ? 1'b0 : r_drop;
    assign sum_v  = clear ? '0 : r_sum;
    assign room   = pos_v < POS_W'(BUFFER_DEPTH);
    assign sum_ok = (pos_v >= POS_W'(3)) && !drop_v
                    && (sum_v[7:0] == r_last2) && (sum_v[15:8] == r_last1);

    always_comb begin
        n_in_frame = r_in_frame || is_start;
        n_pos      = pos_v;
        n_drop     = drop_v;
        n_sum      = sum_v;
        n_last1    = r_last1;
        n_last2    = r_last2;
        if (!emit) begin
            if (room) begin
                n_pos   = pos_v + POS_W'(1);
                n_last1 = i_req.data;
                n_last2 = r_last1;
                if (pos_v >= POS_W'(3)) begin
                    n_sum = sum_v + SUM_W'(r_last2);
                end
            end else begin
                n_drop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= START_CODE_RST;
            r_end_code   <= END_CODE_RST;
            r_in_frame   <= 1'b0;
            r_pos        <= '0;
            r_drop       <= 1'b0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_CODE: r_start_code <= i_cfg_data;
                    CFG_END_CODE:   r_end_code   <= i_cfg_data;
                    default:        r_start_code <= r_start_code;
                endcase
            end
            if (o_consume) begin
                r_in_frame <= n_in_frame;
                r_pos      <= n_pos;
                r_drop     <= n_drop;
                r_sum      <= n_sum;
            end
            if (o_consume && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: byte history and result fields
    always_ff @(posedge i_clk) begin
        if (o_consume) begin
            r_last1 <= n_last1;
            r_last2 <= n_last2;
            if (!emit) begin
                if (pos_v == POS_W'(1)) r_b1 <= i_req.data;
                if (pos_v == POS_W'(2)) r_b2 <= i_req.data;
                if (pos_v == POS_W'(3)) r_b3 <= i_req.data;
                if (pos_v == POS_W'(4)) r_b4 <= i_req.data;
                if (pos_v == POS_W'(5)) r_b5 <= i_req.data;
            end
        end
        if (o_consume && emit) begin
            r_address      <= (pos_v > POS_W'(1)) ? r_b1 : 8'h00;
            r_type_code    <= (pos_v > POS_W'(2)) ? r_b2 : 8'h00;
            r_data_length  <= (pos_v > POS_W'(3)) ? r_b3 : 8'h00;
            r_data_first   <= (pos_v > POS_W'(4)) ? r_b4 : 8'h00;
            r_data_second  <= (pos_v > POS_W'(5)) ? r_b5 : 8'h00;
            r_frame_length <= LEN_W'(pos_v);
            r_checksum_ok  <= sum_ok;
            r_overflow     <= drop_v;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_address      = r_address;
    assign o_type_code    = r_type_code;
    assign o_data_length  = r_data_length;
    assign o_data_first   = r_data_first;
    assign o_data_second  = r_data_second;
    assign o_frame_length = r_frame_length;
    assign o_checksum_ok  = r_checksum_ok;
    assign o_overflow     = r_overflow;

endmodule

[hw/rtl/delimited_frame_receiver_unit.sv]
// Delimited frame receiver: top level.
//
// Takes one received serial byte per request on the rx channel (valid/ready)
// and assembles frames that open with the start code. An end code inside a
// frame produces one result request on the res channel: header bytes, the
// first two payload bytes, stored length, checksum verdict and overflow.
// The checksum is the 16-bit sum of bytes 1..len-3, compared low byte to
// byte len-2 and high byte to byte len-1.
// Start and end codes are written through the cfg port; the user must write
// them only while idle, and the block itself does not enforce it. A result
// is registered when the frame core takes its end code from the input register.
// Throughput: one byte per cycle while no end code waits on a held result;
// the running sum with a two-byte delay keeps the per-byte work to one
// add and compare. Reset clears the frame state, loads the default codes
// (0x55, 0xAA) and empties both registers. When the result consumer stalls,
// non-ending bytes keep flowing; an end code waits in the input register
// until the result register frees, and rx ready is low only while it waits.
module delimited_frame_receiver_unit
    import dfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_rx_valid,
    output logic             o_rx_ready,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic [7:0]       o_address,
    output logic [7:0]       o_type_code,
    output logic [7:0]       o_data_length,
    output logic [7:0]       o_data_first,
    output logic [7:0]       o_data_second,
    output logic [LEN_W-1:0] o_frame_length,
    output logic             o_checksum_ok,
    output logic             o_overflow
);

    t_rx_req req;
    logic    consume;

    dfr_input_stage u_input (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .o_req      (req),
        .i_consume  (consume)
    );

    dfr_frame_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_req          (req),
        .o_consume      (consume),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_address      (o_address),
        .o_type_code    (o_type_code),
        .o_data_length  (o_data_length),
        .o_data_first   (o_data_first),
        .o_data_second  (o_data_second),
        .o_frame_length (o_frame_length),
        .o_checksum_ok  (o_checksum_ok),
        .o_overflow     (o_overflow)
    );

    // the input side stalls only behind a held result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> o_res_valid)
        else $error("rx stalled with empty result register");

    a_ok_not_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_checksum_ok) |-> (!o_overflow && o_frame_length >= LEN_W'(3)))
        else $error("checksum pass on overflowed or short frame");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_overflow) |-> (o_frame_length == LEN_W'(BUFFER_DEPTH)))
        else $error("overflow reported with buffer not full");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_frame_length <= LEN_W'(BUFFER_DEPTH)))
        else $error("frame length beyond buffer depth");

endmodule

[dv/delimited_frame_receiver_unit_tb.sv]
// Self-checking testbench for the delimited frame receiver top level.
module delimited_frame_receiver_unit_tb
    import dfr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 250;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [7:0]       address;
        logic [7:0]       type_code;
        logic [7:0]       data_length;
        logic [7:0]       data_first;
        logic [7:0]       data_second;
        logic [LEN_W-1:0] frame_length;
        logic             checksum_ok;
        logic             overflow;
    } t_frame_report;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic             i_cfg_index   = CFG_START_CODE;
    logic [7:0]       i_cfg_data    = 8'h00;
    logic             i_rx_valid    = 1'b0;
    logic [7:0]       i_rx_byte     = 8'h00;
    logic             i_res_ready   = 1'b0;
    logic             o_rx_ready;
    logic             o_res_valid;
    logic [7:0]       o_address;
    logic [7:0]       o_type_code;
    logic [7:0]       o_data_length;
    logic [7:0]       o_data_first;
    logic [7:0]       o_data_second;
    logic [LEN_W-1:0] o_frame_length;
    logic             o_checksum_ok;
    logic             o_overflow;

    // frame assembly state mirrored from the block
    logic [7:0]  start_code_q = START_CODE_RST;
    logic [7:0]  end_code_q   = END_CODE_RST;
    logic        in_frame_q   = 1'b0;
    logic [7:0]  frame_buf [BUFFER_DEPTH];
    int unsigned fill_pos     = 0;
    logic        overflow_q   = 1'b0;

    t_frame_report frame_reports[$];

    bit rx_quiet   = 1'b0;
    bit res_quiet  = 1'b0;
    bit hold_start = 1'b0;

    int unsigned rx_count     = 0;
    int unsigned report_count = 0;
    int unsigned good_count   = 0;
    int unsigned ovf_count    = 0;
    int unsigned cfg_count    = 0;
    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;

    delimited_frame_receiver_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_address      (o_address),
        .o_type_code    (o_type_code),
        .o_data_length  (o_data_length),
        .o_data_first   (o_data_first),
        .o_data_second  (o_data_second),
        .o_frame_length (o_frame_length),
        .o_checksum_ok  (o_checksum_ok),
        .o_overflow     (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("delimited_frame_receiver_unit_tb: done, errors");
            $finish;
        end
    end

    function automatic void clear_frame();
        for (int k = 0; k < BUFFER_DEPTH; k++) begin
            frame_buf[k] = 8'h00;
        end
        fill_pos   = 0;
        overflow_q = 1'b0;
    endfunction

    function automatic logic [7:0] stored_byte(input int unsigned k);
        return (k < fill_pos) ? frame_buf[k] : 8'h00;
    endfunction

    // Advance the frame state by one byte; return 1 when a report is due.
    function automatic bit advance_frame(input logic [7:0] b, output t_frame_report r);
        int unsigned sum;
        r = '0;
        if (b == start_code_q) begin
            in_frame_q = 1'b1;
            clear_frame();
        end
        if (b == end_code_q && in_frame_q) begin
            r.address      = stored_byte(1);
            r.type_code    = stored_byte(2);
            r.data_length  = stored_byte(3);
            r.data_first   = stored_byte(4);
            r.data_second  = stored_byte(5);
            r.frame_length = fill_pos[LEN_W-1:0];
            r.overflow     = overflow_q;
            if (fill_pos >= 3 && !overflow_q) begin
                sum = 0;
                for (int unsigned k = 1; k + 2 < fill_pos; k++) begin
                    sum += frame_buf[k];
                end
                r.checksum_ok = (sum[7:0] == frame_buf[fill_pos-2]) &&
                                (sum[15:8] == frame_buf[fill_pos-1]);
            end
            return 1'b1;
        end
        // end code outside a frame restarts the buffer without opening a frame
        if (b == end_code_q) begin
            clear_frame();
        end
        if (fill_pos < BUFFER_DEPTH) begin
            frame_buf[fill_pos] = b;
            fill_pos++;
        end else begin
            overflow_q = 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH at cycle %0d, %s: got 0x%0h, expected 0x%0h",
                 cycle_count, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_frame_report want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            report_count++;
            if (frame_reports.size() == 0) begin
                report_mismatch("unexpected frame report, address", o_address, 0);
            end else begin
                want = frame_reports.pop_front();
                if (o_address !== want.address)
                    report_mismatch("address", o_address, want.address);
                if (o_type_code !== want.type_code)
                    report_mismatch("type_code", o_type_code, want.type_code);
                if (o_data_length !== want.data_length)
                    report_mismatch("data_length", o_data_length, want.data_length);
                if (o_data_first !== want.data_first)
                    report_mismatch("data_first", o_data_first, want.data_first);
                if (o_data_second !== want.data_second)
                    report_mismatch("data_second", o_data_second, want.data_second);
                if (o_frame_length !== want.frame_length)
                    report_mismatch("frame_length", o_frame_length, want.frame_length);
                if (o_checksum_ok !== want.checksum_ok)
                    report_mismatch("checksum_ok", o_checksum_ok, want.checksum_ok);
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", o_overflow, want.overflow);
                if (want.checksum_ok)
                    good_count++;
                if (want.overflow)
                    ovf_count++;
            end
        end
    end

    // Result consumer: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!res_quiet && $urandom_range(0, 5) == 0) begin
                i_res_ready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge i_clk);
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        t_frame_report r;
        if (!rx_quiet && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 15)) begin
                @(negedge i_clk);
                i_rx_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        rx_count++;
        if (advance_frame(b, r))
            frame_reports.push_back(r);
    endtask

    task automatic send_seq(input logic [7:0] seq[$]);
        foreach (seq[k])
            send_byte(seq[k]);
    endtask

    // Hold the sender until every pending report has arrived, then let the
    // input stage settle.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (frame_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (frame_reports.size() != 0) begin
            report_mismatch("frame reports never delivered", frame_reports.size(), 0);
            frame_reports.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_codes(input logic [7:0] start_v, input logic [7:0] end_v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_CODE;
        i_cfg_data  <= start_v;
        @(negedge i_clk);
        i_cfg_index <= CFG_END_CODE;
        i_cfg_data  <= end_v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        start_code_q = start_v;
        end_code_q   = end_v;
        cfg_count++;
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do b = $urandom_range(0, 255); while (b == start_code_q || b == end_code_q);
        return b;
    endfunction

    // Build a frame: start, header, payload, checksum, then the end codes.
    task automatic send_frame(input int n_payload, input bit corrupt, input int n_ends);
        logic [7:0]  seq[$];
        logic [15:0] sum;
        int          idx;
        seq.push_back(start_code_q);
        seq.push_back(body_byte());
        seq.push_back(body_byte());
        if ($urandom_range(0, 3) == 0 || n_payload[7:0] == start_code_q ||
            n_payload[7:0] == end_code_q)
            seq.push_back(body_byte());
        else
            seq.push_back(n_payload[7:0]);
        repeat (n_payload) seq.push_back(body_byte());
        sum = 16'h0000;
        for (int k = 1; k < seq.size(); k++)
            sum += seq[k];
        seq.push_back(sum[7:0]);
        seq.push_back(sum[15:8]);
        if (corrupt) begin
            idx = $urandom_range(1, seq.size() - 1);
            seq[idx] = seq[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        repeat (n_ends) seq.push_back(end_code_q);
        send_seq(seq);
    endtask

    task automatic send_random_frame();
        logic [7:0] seq[$];
        int         kind;
        int         n;
        kind = $urandom_range(0, 99);
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 26) : $urandom_range(0, 8);
        if (kind < 60) begin
            send_frame(n, 1'b0, ($urandom_range(0, 9) == 0) ? 2 : 1);
        end else if (kind < 70) begin
            send_frame(n, 1'b1, 1);
        end else if (kind < 76) begin
            send_frame($urandom_range(27, 40), 1'b0, 1);
        end else if (kind < 84) begin
            seq.push_back(start_code_q);
            repeat ($urandom_range(0, 2)) seq.push_back(body_byte());
            seq.push_back(end_code_q);
            send_seq(seq);
        end else if (kind < 90) begin
            // drop the end code; the next start must restart the buffer
            send_frame(n, 1'b0, 0);
        end else begin
            repeat ($urandom_range(1, 6)) seq.push_back($urandom_range(0, 255));
            send_seq(seq);
        end
    endtask

    task automatic test_reset_delimiters();
        logic [7:0] seq[$];
        // bytes before any start code, an end code outside a frame, short
        // frames, repeated end, minimal good frame, extreme header values
        seq = '{8'h12, END_CODE_RST, 8'h34,
                START_CODE_RST, END_CODE_RST, END_CODE_RST,
                START_CODE_RST, 8'h00, 8'h00, END_CODE_RST,
                START_CODE_RST, 8'hFF, END_CODE_RST,
                START_CODE_RST, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'hFE, 8'h00, 8'h03,
                END_CODE_RST};
        send_seq(seq);
        wait_for_results();
    endtask

    task automatic test_equal_codes();
        logic [7:0] seq[$];
        write_codes(8'h3C, 8'h3C);
        seq = '{8'h3C, 8'h11, 8'h22, 8'h3C};
        send_seq(seq);
        wait_for_results();
    endtask

    task automatic test_random_frames(input int unsigned n_items);
        int unsigned target;
        target = rx_count + n_items;
        while (rx_count < target)
            send_random_frame();
        wait_for_results();
    endtask

    task automatic test_stalled_receiver();
        wait_for_results();
        @(posedge i_clk);
        hold_start = 1'b1;
        rx_quiet   = 1'b1;
        repeat (10) send_frame($urandom_range(0, 4), 1'b0, 1);
        rx_quiet   = 1'b0;
        wait_for_results();
    endtask

    initial begin
        logic [7:0] s;
        logic [7:0] e;
        clear_frame();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_delimiters();
        test_random_frames(350);
        test_stalled_receiver();

        write_codes(8'h00, 8'hFF);
        test_random_frames(200);
        write_codes(8'hFF, 8'h00);
        test_random_frames(200);

        test_equal_codes();
        test_random_frames(120);

        s = $urandom_range(0, 255);
        do e = $urandom_range(0, 255); while (e == s);
        write_codes(s, e);
        test_random_frames(200);

        // last stretch runs at full rate on both sides
        write_codes(START_CODE_RST, END_CODE_RST);
        rx_quiet  = 1'b1;
        res_quiet = 1'b1;
        test_random_frames(200);

        $display("sent %0d bytes under %0d code settings plus reset defaults",
                 rx_count, cfg_count);
        $display("checked %0d frame reports: %0d with good checksum, %0d overflowed",
                 report_count, good_count, ovf_count);
        if (err_count == 0) begin
            $display("delimited_frame_receiver_unit_tb: done, clean");
        end else begin
            $display("delimited_frame_receiver_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
